>>> hdl/brba_pkg.sv
// shared types, codes and constants of the bitmap run block allocator
// no dependencies; used by bitmap_run_block_allocator_core
package brba_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 32;
  localparam int unsigned POOL_BLOCKS_DEF   = 32;
  localparam int unsigned BLOCK_SHIFT_DEF   = 9;

  localparam int unsigned MAP_W     = 32;
  localparam int unsigned START_W   = 5;
  localparam int unsigned LEN_W     = 6;
  localparam int unsigned TAG_W     = 32;
  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned COUNT_W   = 8;
  localparam int unsigned IDXF_W    = 8;
  localparam int unsigned MAX_COUNT = 32;

  typedef enum logic [1:0] {
    MODE_ALLOC,
    MODE_FREE,
    MODE_SUSPEND,
    MODE_RESUME
  } mode_e;

  typedef enum logic [2:0] {
    ST_OK,
    ST_LOCKED,
    ST_BAD_COUNT,
    ST_NO_RUN,
    ST_TABLE_FULL,
    ST_NOT_FOUND,
    ST_NO_CHANGE
  } status_e;

  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic [LEN_W-1:0]   len;
    logic [START_W-1:0] start;
  } ent_t;

  typedef struct packed {
    status_e            status;
    logic [ADDR_W-1:0]  addr;
    logic [START_W-1:0] start;
    logic [LEN_W-1:0]   len;
    logic [TAG_W-1:0]   tag;
    logic               is_notice;
    logic               resuming;
    logic               last;
  } res_t;

  // block 0 sits in the most significant bit
  function automatic logic [MAP_W-1:0] run_mask(input logic [START_W-1:0] start,
                                                input logic [LEN_W-1:0]   len);
    logic [MAP_W-1:0] top;
    top = ~({MAP_W{1'b1}} >> len);
    return top >> start;
  endfunction

endpackage

>>> hdl/brba_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module brba_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/bitmap_run_block_allocator_core.sv
// top level of the bitmap run block allocator: request decode, scans and result register
// depends on brba_pkg and brba_ram
//
// One request at a time. Allocate scans one candidate start per cycle against the occupancy
// map while it looks for a free table slot in the valid flags, one slot per cycle, and then
// loads its result. Free walks the entry ram through its single read port, one entry per
// cycle, and loads its result. Suspend/resume walk every entry the same way, one notice per
// reported entry, but stall on a reported entry until its notice can be loaded, and then load
// the closing result. Every result load waits while an earlier result is held by a low
// m_axis_tready, and the next request is taken in the cycle after the last result is loaded.
// Entry validity is kept in flip-flops, so the block is ready right after reset. The table
// ram holds start, length and tag of each entry.
module bitmap_run_block_allocator_core #(
  parameter int unsigned TABLE_ENTRIES = brba_pkg::TABLE_ENTRIES_DEF,
  parameter int unsigned POOL_BLOCKS   = brba_pkg::POOL_BLOCKS_DEF,
  parameter int unsigned BLOCK_SHIFT   = brba_pkg::BLOCK_SHIFT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_wdata_i,   // pool_base
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // block_count, owner_tag, free_address
  input  logic [1:0]  s_axis_tuser,  // mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,  // status, block_address, entry_start, entry_length,
                                     // entry_tag, zero pad
  output logic [1:0]  m_axis_tuser,  // is_notice, resuming
  output logic        m_axis_tlast
);

  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] ELast = IDX_W'(TABLE_ENTRIES - 1);
  localparam logic [brba_pkg::START_W-1:0] SLast = brba_pkg::START_W'(POOL_BLOCKS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ERR,
    S_ALLOC,
    S_COMMIT,
    S_FREE_CHK,
    S_WALK_CHK,
    S_WALK_END
  } state_e;

  state_e                          state_q;
  logic [brba_pkg::ADDR_W-1:0]     pool_base_q;
  logic [brba_pkg::MAP_W-1:0]      map_q;
  logic                            locked_q;
  logic [TABLE_ENTRIES-1:0]        valid_q;
  logic [IDX_W-1:0]                e_q;
  logic [brba_pkg::START_W-1:0]    s_q;
  logic                            run_hit_q, run_none_q, ent_hit_q, ent_none_q;
  brba_pkg::status_e               err_q;
  logic                            res_q;
  logic                            m_valid_q;
  brba_pkg::res_t                  out_q;
  logic [brba_pkg::LEN_W-1:0]      count_q;
  logic [brba_pkg::TAG_W-1:0]      tag_q;
  logic [brba_pkg::IDXF_W-1:0]     idx_q;

  brba_pkg::mode_e                 in_mode;
  logic [brba_pkg::COUNT_W-1:0]    in_count;
  logic [brba_pkg::TAG_W-1:0]      in_tag;
  logic [brba_pkg::ADDR_W-1:0]     in_faddr;
  logic [brba_pkg::ADDR_W-1:0]     fdiff, fshift;
  logic                            s_fire, can_load;
  logic                            acc_err;
  brba_pkg::status_e               acc_status;

  logic [brba_pkg::START_W+1:0]    run_end;
  logic                            fit, free_hit, walk_need, e_last, s_last;
  brba_pkg::ent_t                  rd_ent, wr_ent;
  logic [$bits(brba_pkg::ent_t)-1:0] ram_rdata;
  logic                            ram_we, ram_re;
  logic [IDX_W-1:0]                rd_addr;
  logic                            load;
  brba_pkg::res_t                  res_d;

  assign in_mode  = brba_pkg::mode_e'(s_axis_tuser);
  assign in_count = s_axis_tdata[7:0];
  assign in_tag   = s_axis_tdata[39:8];
  assign in_faddr = s_axis_tdata[71:40];
  assign fdiff    = in_faddr - pool_base_q;
  assign fshift   = fdiff >> BLOCK_SHIFT;

  assign s_axis_tready = (state_q == S_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign can_load      = !m_valid_q || m_axis_tready;
  assign cfg_ready_o   = 1'b1;

  always_comb begin
    acc_err    = 1'b0;
    acc_status = brba_pkg::ST_OK;
    unique case (in_mode)
      brba_pkg::MODE_ALLOC: begin
        if (locked_q) begin
          acc_err    = 1'b1;
          acc_status = brba_pkg::ST_LOCKED;
        end else if (in_count == '0 ||
                     in_count > brba_pkg::COUNT_W'(brba_pkg::MAX_COUNT)) begin
          acc_err    = 1'b1;
          acc_status = brba_pkg::ST_BAD_COUNT;
        end
      end
      brba_pkg::MODE_FREE: begin
        acc_err = 1'b0;
      end
      brba_pkg::MODE_SUSPEND: begin
        if (locked_q) begin
          acc_err    = 1'b1;
          acc_status = brba_pkg::ST_NO_CHANGE;
        end
      end
      brba_pkg::MODE_RESUME: begin
        if (!locked_q) begin
          acc_err    = 1'b1;
          acc_status = brba_pkg::ST_NO_CHANGE;
        end
      end
      default: begin
        acc_err = 1'b0;
      end
    endcase
  end

  assign rd_ent  = brba_pkg::ent_t'(ram_rdata);
  assign run_end = (brba_pkg::START_W + 2)'(s_q) + (brba_pkg::START_W + 2)'(count_q);
  assign fit     = (run_end <= (brba_pkg::START_W + 2)'(POOL_BLOCKS)) &&
                   ((map_q & brba_pkg::run_mask(s_q, count_q)) == '0);
  assign free_hit  = valid_q[e_q] && (idx_q[brba_pkg::IDXF_W-1:brba_pkg::START_W] == '0) &&
                     (rd_ent.start == idx_q[brba_pkg::START_W-1:0]);
  assign walk_need = valid_q[e_q] && (rd_ent.tag != '0);
  assign e_last    = (e_q == ELast);
  assign s_last    = (s_q == SLast);

  assign wr_ent = '{tag: tag_q, len: count_q, start: s_q};

  always_comb begin
    load    = 1'b0;
    res_d   = '0;
    ram_we  = 1'b0;
    ram_re  = 1'b0;
    rd_addr = e_q + IDX_W'(1);
    unique case (state_q)
      S_IDLE: begin
        ram_re  = 1'b1;
        rd_addr = '0;
      end
      S_ERR: begin
        load           = can_load;
        res_d.status   = err_q;
        res_d.resuming = res_q;
        res_d.last     = 1'b1;
      end
      S_ALLOC: begin
        load = 1'b0;
      end
      S_COMMIT: begin
        load         = can_load;
        ram_we       = can_load;
        res_d.status = brba_pkg::ST_OK;
        res_d.addr   = pool_base_q + (brba_pkg::ADDR_W'(s_q) << BLOCK_SHIFT);
        res_d.start  = s_q;
        res_d.len    = count_q;
        res_d.last   = 1'b1;
      end
      S_FREE_CHK: begin
        if (free_hit) begin
          load         = can_load;
          res_d.status = brba_pkg::ST_OK;
          res_d.start  = rd_ent.start;
          res_d.len    = rd_ent.len;
          res_d.last   = 1'b1;
        end else if (e_last) begin
          load         = can_load;
          res_d.status = brba_pkg::ST_NOT_FOUND;
          res_d.last   = 1'b1;
        end else begin
          ram_re = 1'b1;
        end
      end
      S_WALK_CHK: begin
        if (walk_need) begin
          load            = can_load;
          res_d.status    = brba_pkg::ST_OK;
          res_d.addr      = pool_base_q + (brba_pkg::ADDR_W'(rd_ent.start) << BLOCK_SHIFT);
          res_d.start     = rd_ent.start;
          res_d.len       = rd_ent.len;
          res_d.tag       = rd_ent.tag;
          res_d.is_notice = 1'b1;
          res_d.resuming  = res_q;
        end
        ram_re = !e_last && (!walk_need || can_load);
      end
      S_WALK_END: begin
        load           = can_load;
        res_d.status   = brba_pkg::ST_OK;
        res_d.resuming = res_q;
        res_d.last     = 1'b1;
      end
      default: begin
        load = 1'b0;
      end
    endcase
  end

  brba_ram #(
    .WIDTH($bits(brba_pkg::ent_t)),
    .DEPTH(TABLE_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (e_q),
    .wdata_i (wr_ent),
    .re_i    (ram_re),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pool_base_q <= '0;
      map_q       <= '0;
      locked_q    <= 1'b0;
      valid_q     <= '0;
      e_q         <= '0;
      s_q         <= '0;
      run_hit_q   <= 1'b0;
      run_none_q  <= 1'b0;
      ent_hit_q   <= 1'b0;
      ent_none_q  <= 1'b0;
      err_q       <= brba_pkg::ST_OK;
      res_q       <= 1'b0;
      m_valid_q   <= 1'b0;
      out_q       <= '0;
      count_q     <= '0;
      tag_q       <= '0;
      idx_q       <= '0;
    end else begin
      if (cfg_valid_i) begin
        pool_base_q <= cfg_wdata_i;
      end
      if (load) begin
        m_valid_q <= 1'b1;
        out_q     <= res_d;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      if (s_fire) begin
        count_q <= in_count[brba_pkg::LEN_W-1:0];
        tag_q   <= in_tag;
        idx_q   <= fshift[brba_pkg::IDXF_W-1:0];
      end
      unique case (state_q)
        S_IDLE: begin
          if (s_fire) begin
            e_q        <= '0;
            s_q        <= '0;
            run_hit_q  <= 1'b0;
            run_none_q <= 1'b0;
            ent_hit_q  <= 1'b0;
            ent_none_q <= 1'b0;
            err_q      <= acc_status;
            res_q      <= (in_mode == brba_pkg::MODE_RESUME);
            if (acc_err) begin
              state_q <= S_ERR;
            end else begin
              unique case (in_mode)
                brba_pkg::MODE_ALLOC:   state_q <= S_ALLOC;
                brba_pkg::MODE_FREE:    state_q <= S_FREE_CHK;
                brba_pkg::MODE_SUSPEND: state_q <= S_WALK_CHK;
                brba_pkg::MODE_RESUME:  state_q <= S_WALK_CHK;
                default:                state_q <= S_IDLE;
              endcase
            end
          end
        end
        S_ERR: begin
          if (can_load) begin
            state_q <= S_IDLE;
          end
        end
        S_ALLOC: begin
          if (!run_hit_q && !run_none_q) begin
            if (fit) begin
              run_hit_q <= 1'b1;
            end else if (s_last) begin
              run_none_q <= 1'b1;
            end else begin
              s_q <= s_q + brba_pkg::START_W'(1);
            end
          end
          if (!ent_hit_q && !ent_none_q) begin
            if (!valid_q[e_q]) begin
              ent_hit_q <= 1'b1;
            end else if (e_last) begin
              ent_none_q <= 1'b1;
            end else begin
              e_q <= e_q + IDX_W'(1);
            end
          end
          if (run_none_q) begin
            err_q   <= brba_pkg::ST_NO_RUN;
            state_q <= S_ERR;
          end else if (run_hit_q && ent_none_q) begin
            err_q   <= brba_pkg::ST_TABLE_FULL;
            state_q <= S_ERR;
          end else if (run_hit_q && ent_hit_q) begin
            state_q <= S_COMMIT;
          end
        end
        S_COMMIT: begin
          if (can_load) begin
            valid_q[e_q] <= 1'b1;
            map_q        <= map_q | brba_pkg::run_mask(s_q, count_q);
            state_q      <= S_IDLE;
          end
        end
        S_FREE_CHK: begin
          if (free_hit) begin
            if (can_load) begin
              valid_q[e_q] <= 1'b0;
              map_q        <= map_q & ~brba_pkg::run_mask(rd_ent.start, rd_ent.len);
              state_q      <= S_IDLE;
            end
          end else if (e_last) begin
            if (can_load) begin
              state_q <= S_IDLE;
            end
          end else begin
            e_q <= e_q + IDX_W'(1);
          end
        end
        S_WALK_CHK: begin
          if (!walk_need || can_load) begin
            if (e_last) begin
              state_q <= S_WALK_END;
            end else begin
              e_q <= e_q + IDX_W'(1);
            end
          end
        end
        S_WALK_END: begin
          if (can_load) begin
            locked_q <= !res_q;
            state_q  <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {2'b00, out_q.tag, out_q.len, out_q.start, out_q.addr, out_q.status};
  assign m_axis_tuser  = {out_q.resuming, out_q.is_notice};
  assign m_axis_tlast  = out_q.last;

endmodule
